// ===== design/trd_pkg.sv =====
// Types, phase codes and geometry helpers for the planar tile RLE decoder.
// Used by every module in the design folder; depends on nothing.
package trd_pkg;

  localparam int unsigned MaxTilePixels = 4096;
  localparam int unsigned PixW          = 13;
  localparam int unsigned PosW          = 12;
  localparam int unsigned RemW          = 16;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic REG_CHANNELS    = 1'b0;
  localparam logic REG_TILE_PIXELS = 1'b1;

  localparam logic [7:0] HDR_SPLIT = 8'd128;
  localparam logic [7:0] HDR_LONG_REPEAT = 8'd127;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CNT_HI  = 3'd1,
    PH_CNT_LO  = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_LITERAL = 3'd4,
    PH_DRAIN   = 3'd5,
    PH_DONE    = 3'd6
  } trd_phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       tile_start;
  } trd_in_t;

  typedef struct packed {
    logic [7:0]      run_value;
    logic [1:0]      run_channel;
    logic [PosW-1:0] first_pixel;
    logic [PixW-1:0] run_length;
    logic            overrun;
    logic            tile_done;
  } trd_out_t;

  // Effective geometry after clamping the raw register values
  typedef struct packed {
    logic [2:0]      chan_cnt;
    logic [PixW-1:0] plane_pixels;
  } trd_geom_t;

  function automatic logic [2:0] eff_channels(input logic [2:0] raw);
    logic [2:0] res;
    res = raw;
    if (raw == 3'd0) res = 3'd1;
    else if (raw > 3'd4) res = 3'd4;
    return res;
  endfunction

  function automatic logic [PixW-1:0] eff_pixels(input logic [PixW-1:0] raw);
    logic [PixW-1:0] res;
    res = raw;
    if (raw == '0) res = PixW'(1);
    else if (raw > PixW'(MaxTilePixels)) res = PixW'(MaxTilePixels);
    return res;
  endfunction

endpackage

// ===== design/trd_cfg_regs.sv =====
// APB register file: channel count and tile pixel count, plus clamped geometry.
// Depends on trd_pkg.
module trd_cfg_regs import trd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output trd_geom_t       geom
);

  logic [2:0]      channels_r;
  logic [PixW-1:0] tile_pixels_r;
  logic            wr_en;
  logic            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r    <= 3'd4;
      tile_pixels_r <= PixW'(MaxTilePixels);
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHANNELS:    channels_r    <= pwdata[2:0];
        REG_TILE_PIXELS: tile_pixels_r <= pwdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHANNELS:    prdata = {29'd0, channels_r};
      REG_TILE_PIXELS: prdata = {{(32-PixW){1'b0}}, tile_pixels_r};
      default:         prdata = '0;
    endcase
  end

  assign geom.chan_cnt     = eff_channels(channels_r);
  assign geom.plane_pixels = eff_pixels(tile_pixels_r);

endmodule

// ===== design/trd_decode_core.sv =====
// Decode state (phase, run count, pixel and channel position) and the
// per-byte next-state and run descriptor logic. Depends on trd_pkg.
module trd_decode_core import trd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  trd_geom_t geom,
  input  logic      item_go,
  input  trd_in_t   item,
  output logic      res_valid,
  output trd_out_t  res
);

  trd_phase_t      phase_r, phase_nxt;
  logic            lit_r, lit_nxt;
  logic [7:0]      cnt_hi_r, cnt_hi_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [PixW-1:0] pos_r, pos_nxt;
  logic [1:0]      chan_r, chan_nxt;

  trd_phase_t      ph_in;
  logic [RemW-1:0] rem_in;
  logic [PixW-1:0] pos_raw, pos_c;
  logic [2:0]      chan_raw, chan_c;
  logic [PixW-1:0] left;
  logic            rep_ov;
  logic [PixW-1:0] adv_n;
  logic [PixW-1:0] adv_sum;
  logic            adv_wrap;
  logic            adv_tile;
  logic [RemW-1:0] rem_dec;
  logic [7:0]      b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      lit_r    <= 1'b0;
      cnt_hi_r <= '0;
      rem_r    <= '0;
      pos_r    <= '0;
      chan_r   <= '0;
    end else if (item_go) begin
      phase_r  <= phase_nxt;
      lit_r    <= lit_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      chan_r   <= chan_nxt;
    end
  end

  // Tile start restarts the position; then clamp against the current geometry
  always_comb begin
    b        = item.code_byte;
    ph_in    = item.tile_start ? PH_HEADER : phase_r;
    rem_in   = item.tile_start ? '0 : rem_r;
    pos_raw  = item.tile_start ? '0 : pos_r;
    chan_raw = item.tile_start ? 3'd0 : {1'b0, chan_r};
    pos_c    = (pos_raw >= geom.plane_pixels) ? geom.plane_pixels - PixW'(1) : pos_raw;
    chan_c   = (chan_raw >= geom.chan_cnt) ? geom.chan_cnt - 3'd1 : chan_raw;
    left     = geom.plane_pixels - pos_c;
    rep_ov   = rem_in > RemW'(left);
    rem_dec  = rem_in - RemW'(1);
  end

  // Shared position advance: by the clipped repeat length or by one literal
  always_comb begin
    adv_n    = (ph_in == PH_REPEAT) ? (rep_ov ? left : rem_in[PixW-1:0]) : PixW'(1);
    adv_sum  = pos_c + adv_n;
    adv_wrap = adv_sum >= geom.plane_pixels;
    adv_tile = adv_wrap && ((chan_c + 3'd1) >= geom.chan_cnt);
  end

  always_comb begin
    phase_nxt  = ph_in;
    lit_nxt    = lit_r;
    cnt_hi_nxt = cnt_hi_r;
    rem_nxt    = rem_in;
    pos_nxt    = pos_c;
    chan_nxt   = chan_c[1:0];
    res_valid  = 1'b0;
    res.run_value   = b;
    res.run_channel = chan_c[1:0];
    res.first_pixel = pos_c[PosW-1:0];
    res.run_length  = adv_n;
    res.overrun     = 1'b0;
    res.tile_done   = adv_tile;

    case (ph_in)
      PH_CNT_HI: begin
        cnt_hi_nxt = b;
        phase_nxt  = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        rem_nxt = {cnt_hi_r, b};
        if (lit_r) phase_nxt = ({cnt_hi_r, b} == '0) ? PH_HEADER : PH_LITERAL;
        else       phase_nxt = PH_REPEAT;
      end
      PH_REPEAT: begin
        phase_nxt = PH_HEADER;
        if (rem_in != '0) begin
          res_valid   = 1'b1;
          res.overrun = rep_ov;
          rem_nxt     = '0;
          if (adv_wrap) begin
            pos_nxt  = '0;
            chan_nxt = adv_tile ? 2'd0 : chan_c[1:0] + 2'd1;
          end else begin
            pos_nxt = adv_sum;
          end
          if (adv_tile) phase_nxt = PH_DONE;
        end
      end
      PH_LITERAL: begin
        res_valid   = 1'b1;
        rem_nxt     = rem_dec;
        res.overrun = adv_wrap && (rem_dec != '0);
        if (adv_wrap) begin
          pos_nxt  = '0;
          chan_nxt = adv_tile ? 2'd0 : chan_c[1:0] + 2'd1;
        end else begin
          pos_nxt = adv_sum;
        end
        if (adv_tile)             phase_nxt = PH_DONE;
        else if (rem_dec == '0)   phase_nxt = PH_HEADER;
        else if (adv_wrap)        phase_nxt = PH_DRAIN;
        else                      phase_nxt = PH_LITERAL;
      end
      PH_DRAIN: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_HEADER;
      end
      PH_DONE: ;
      default: begin
        // header byte, also taken for the unused phase code
        lit_nxt = b[7];
        if (b[7]) begin
          if (b == HDR_SPLIT) begin
            phase_nxt = PH_CNT_HI;
          end else begin
            rem_nxt   = RemW'(9'd256 - {1'b0, b});
            phase_nxt = PH_LITERAL;
          end
        end else begin
          if (b == HDR_LONG_REPEAT) begin
            phase_nxt = PH_CNT_HI;
          end else begin
            rem_nxt   = RemW'(b) + RemW'(1);
            phase_nxt = PH_REPEAT;
          end
        end
      end
    endcase
  end

endmodule

// ===== design/planar_tile_rle_decoder_unit.sv =====
// Planar tile RLE decoder: one coded byte per input beat, at most one run
// descriptor per result beat. Unless stalled, a byte is taken every cycle:
// it lands in the input register, the decode logic updates phase, count and
// position from it in one pass, and any descriptor goes to the output
// register; the input stalls behind a stalled result. Literal bytes each
// give a run of length one unless drained; header and count bytes give
// nothing. Channel count and tile size must be written through the APB port
// (offset 0 and 4) only between tiles, with the block drained; the block
// does not enforce this. Depends on trd_pkg, trd_cfg_regs, trd_decode_core.
module planar_tile_rle_decoder_unit import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  trd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output trd_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  trd_geom_t geom;
  logic      in_valid_r, in_valid_nxt;
  trd_in_t   in_data_r;
  logic      out_valid_r, out_valid_nxt;
  trd_out_t  out_data_r;
  logic      go;
  logic      take;
  logic      res_valid;
  trd_out_t  res;

  trd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  trd_decode_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .item_go   (go),
    .item      (in_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Advance the held byte once the output register is free or draining
  assign go       = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~go;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = take | (in_valid_r & ~go);
    if (go)              out_valid_nxt = res_valid;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_data_r <= in_data;
    if (go && res_valid) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
